>>> src/b64d_pkg.sv
// Package for the base64 stream decoder: item types, decoder state, status codes
// and the alphabet lookup. Depends on nothing; every other file imports it.
`default_nettype none

package b64d_pkg;

    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] STATUS_RUN = 2'd0;
    localparam logic [1:0] STATUS_OK  = 2'd1;
    localparam logic [1:0] STATUS_ERR = 2'd2;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] status;
        logic       end_of_run;
    } out_item_t;

    typedef struct packed {
        logic [1:0] group_pos;
        logic [5:0] hold0;
        logic [5:0] hold1;
        logic [5:0] hold2;
        logic       third_was_pad;
        logic       group_bad;
        logic       seen_data;
        logic       trailing_blank;
        logic       error_flag;
    } dec_state_t;

    localparam dec_state_t STATE_RESET = '0;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } sextet_t;

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t r;
        r = '{ok: 1'b1, value: 6'd0};
        if (c inside {[8'h41:8'h5A]}) begin
            r.value = 6'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            r.value = 6'(c - 8'h61 + 8'd26);
        end else if (c inside {[8'h30:8'h39]}) begin
            r.value = 6'(c - 8'h30 + 8'd52);
        end else if (c == CHAR_PLUS) begin
            r.value = 6'd62;
        end else if (c == CHAR_SLASH) begin
            r.value = 6'd63;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/b64d_step.sv
// Decode step for one character: next decoder state and the result items it causes.
// Purely combinational; depends on b64d_pkg.
`default_nettype none

module b64d_step (
    input  wire b64d_pkg::dec_state_t cur_state,
    input  wire b64d_pkg::in_item_t   item,
    output b64d_pkg::dec_state_t      next_state,
    output logic [b64d_pkg::CNT_W-1:0] result_cnt,
    output b64d_pkg::out_item_t       results [b64d_pkg::MAX_RESULTS]
);
    import b64d_pkg::*;

    dec_state_t st;
    sextet_t    sx;
    logic       blank;
    logic       leading;
    logic       pad;
    logic [1:0] byte_cnt;
    logic [7:0] bytes [3];
    logic [1:0] fin_status;

    always_comb begin
        sx      = sextet_of(item.char_code);
        blank   = (item.char_code == CHAR_SPACE) || (item.char_code == CHAR_TAB);
        leading = blank || (item.char_code == CHAR_CR) || (item.char_code == CHAR_LF);
        pad     = (item.char_code == CHAR_PAD);

        bytes[0] = {cur_state.hold0, cur_state.hold1[5:4]};
        bytes[1] = {cur_state.hold1[3:0], cur_state.hold2[5:2]};
        bytes[2] = {cur_state.hold2[1:0], sx.value};

        st       = cur_state;
        byte_cnt = 2'd0;

        if (!cur_state.seen_data && leading) begin
            st = cur_state;
        end else if (blank) begin
            st.trailing_blank = 1'b1;
        end else if (cur_state.trailing_blank) begin
            st.error_flag = 1'b1;
        end else begin
            st.seen_data = 1'b1;
            case (cur_state.group_pos)
                2'd0: begin
                    st.hold0     = sx.value;
                    st.group_bad = cur_state.group_bad | ~sx.ok;
                    st.group_pos = 2'd1;
                end
                2'd1: begin
                    st.hold1     = sx.value;
                    st.group_bad = cur_state.group_bad | ~sx.ok;
                    st.group_pos = 2'd2;
                end
                2'd2: begin
                    if (pad) begin
                        st.third_was_pad = 1'b1;
                        st.hold2         = 6'd0;
                    end else begin
                        st.hold2     = sx.value;
                        st.group_bad = cur_state.group_bad | ~sx.ok;
                    end
                    st.group_pos = 2'd3;
                end
                default: begin
                    if (cur_state.third_was_pad) begin
                        byte_cnt = 2'd1;
                    end else if (pad) begin
                        byte_cnt = 2'd2;
                    end else begin
                        byte_cnt     = 2'd3;
                        st.group_bad = cur_state.group_bad | ~sx.ok;
                    end
                    st.error_flag = cur_state.error_flag | st.group_bad;
                    if (st.error_flag) begin
                        byte_cnt = 2'd0;
                    end
                    st.group_pos     = 2'd0;
                    st.third_was_pad = 1'b0;
                    st.group_bad     = 1'b0;
                end
            endcase
        end

        fin_status = (st.error_flag || !st.seen_data) ? STATUS_ERR : STATUS_OK;

        for (int i = 0; i < MAX_RESULTS; i++) begin
            results[i] = '0;
            if (i < 3 && CNT_W'(i) < CNT_W'(byte_cnt)) begin
                results[i].out_byte   = bytes[(i < 3) ? 2'(i) : 2'd0];
                results[i].byte_valid = 1'b1;
                results[i].status     = STATUS_RUN;
            end else if (CNT_W'(i) == CNT_W'(byte_cnt)) begin
                results[i].status     = fin_status;
                results[i].end_of_run = 1'b1;
            end
        end

        result_cnt = CNT_W'(byte_cnt) + CNT_W'(item.is_last);
        next_state = item.is_last ? STATE_RESET : st;
    end

endmodule

`default_nettype wire

>>> src/base64_stream_decoder_unit.sv
// Top level of the base64 stream decoder: input register, decode step and result buffer.
// Depends on b64d_pkg and b64d_step.
//
//   port group   dir  payload          meaning
//   s_*          in   in_item_t        one character of text, is_last on the final one
//   m_*          out  out_item_t       decoded byte, or the status item ending a text
//
// A character is decoded from the input register; its bytes leave one per cycle while
// m_ready is high, from a four-slot result buffer whose head slot drives m_data.
// Characters yielding no item flow at one per cycle; a character that yields items waits
// only until the buffer holds at most one item that is leaving in the same cycle.
// Reset (aresetn low at a clock edge) empties both registers and clears the decoder state.
// A stall on m_ready holds the buffer; s_ready then drops once a held character needs room.
`default_nettype none

module base64_stream_decoder_unit (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire b64d_pkg::in_item_t  s_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output b64d_pkg::out_item_t   m_data
);
    import b64d_pkg::*;

    in_item_t   in_item_reg;
    logic       in_vld_reg;
    logic       in_vld_next;

    dec_state_t state_reg;
    dec_state_t state_next;
    dec_state_t step_state;

    out_item_t  slot_reg  [MAX_RESULTS];
    out_item_t  slot_next [MAX_RESULTS];
    out_item_t  step_items [MAX_RESULTS];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] step_cnt;

    logic m_accept;
    logic room;
    logic proc;

    b64d_step u_step (
        .cur_state  (state_reg),
        .item       (in_item_reg),
        .next_state (step_state),
        .result_cnt (step_cnt),
        .results    (step_items)
    );

    always_comb begin
        m_valid  = (cnt_reg != '0);
        m_data   = slot_reg[0];
        m_accept = m_valid && m_ready;
        room     = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && m_ready);
        proc     = in_vld_reg && ((step_cnt == '0) || room);
        s_ready  = !in_vld_reg || proc;
    end

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (proc) begin
            in_vld_next = 1'b0;
        end

        state_next = proc ? step_state : state_reg;

        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (proc && (step_cnt != '0)) begin
            slot_next = step_items;
            cnt_next  = step_cnt;
        end else if (m_accept) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                slot_next[i] = slot_reg[i + 1];
            end
            slot_next[MAX_RESULTS - 1] = '0;
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            state_reg  <= STATE_RESET;
            cnt_reg    <= '0;
        end else begin
            in_vld_reg <= in_vld_next;
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        slot_reg <= slot_next;
    end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for base64_stream_decoder_unit: directed and random base64 texts
// go in through the s_ channel, and a scoreboard class predicts and checks every m_ item.
// Depends on b64d_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;
    import b64d_pkg::*;

    class b64_decode_checker;
        int         sextet_tbl[256];
        out_item_t  due_items[$];
        logic [1:0] grp_pos;
        logic [5:0] held[3];
        bit         pad_third;
        bit         bad_group;
        bit         data_seen;
        bit         blank_seen;
        bit         err_sticky;
        int         fails;

        function new(string alpha);
            int i;
            foreach (sextet_tbl[k]) sextet_tbl[k] = -1;
            for (i = 0; i < alpha.len(); i++) begin
                sextet_tbl[alpha[i]] = i;
            end
            clear_state();
            fails = 0;
        endfunction

        function void clear_state();
            grp_pos    = 2'd0;
            held[0]    = 6'd0;
            held[1]    = 6'd0;
            held[2]    = 6'd0;
            pad_third  = 1'b0;
            bad_group  = 1'b0;
            data_seen  = 1'b0;
            blank_seen = 1'b0;
            err_sticky = 1'b0;
        endfunction

        function void queue_item(logic [7:0] b, logic v, logic [1:0] st, logic eor);
            due_items.push_back('{out_byte: b, byte_valid: v, status: st, end_of_run: eor});
        endfunction

        function int awaiting();
            return due_items.size();
        endfunction

        // Updates the decoder state for one accepted character and queues its output items.
        function void take_char(in_item_t it);
            logic [7:0] c;
            int         code;
            logic [5:0] s;
            bit         blank;
            bit         lead;
            bit         pad;
            int         nbytes;
            c     = it.char_code;
            code  = sextet_tbl[c];
            s     = (code < 0) ? 6'd0 : code[5:0];
            pad   = (c == CHAR_PAD);
            blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
            lead  = blank || (c == CHAR_CR) || (c == CHAR_LF);
            if (!data_seen && lead) begin
            end else if (blank) begin
                blank_seen = 1'b1;
            end else if (blank_seen) begin
                err_sticky = 1'b1;
            end else begin
                data_seen = 1'b1;
                case (grp_pos)
                    2'd0, 2'd1: begin
                        held[grp_pos] = s;
                        if (code < 0) bad_group = 1'b1;
                        grp_pos = grp_pos + 2'd1;
                    end
                    2'd2: begin
                        if (pad) begin
                            pad_third = 1'b1;
                            held[2] = 6'd0;
                        end else begin
                            held[2] = s;
                            if (code < 0) bad_group = 1'b1;
                        end
                        grp_pos = 2'd3;
                    end
                    default: begin
                        if (pad_third) begin
                            nbytes = 1;
                        end else if (pad) begin
                            nbytes = 2;
                        end else begin
                            nbytes = 3;
                            if (code < 0) bad_group = 1'b1;
                        end
                        if (bad_group) err_sticky = 1'b1;
                        if (!err_sticky) begin
                            queue_item({held[0], held[1][5:4]}, 1'b1, STATUS_RUN, 1'b0);
                            if (nbytes >= 2) begin
                                queue_item({held[1][3:0], held[2][5:2]}, 1'b1,
                                    STATUS_RUN, 1'b0);
                            end
                            if (nbytes == 3) begin
                                queue_item({held[2][1:0], s}, 1'b1, STATUS_RUN, 1'b0);
                            end
                        end
                        grp_pos   = 2'd0;
                        pad_third = 1'b0;
                        bad_group = 1'b0;
                    end
                endcase
            end
            if (it.is_last) begin
                queue_item(8'h00, 1'b0, (err_sticky || !data_seen) ? STATUS_ERR : STATUS_OK,
                    1'b1);
                clear_state();
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            fails++;
        endtask

        task check_item(out_item_t got);
            out_item_t want;
            if (due_items.size() == 0) begin
                report_mismatch($sformatf("item with none due: byte=%h valid=%b status=%0d end=%b",
                    got.out_byte, got.byte_valid, got.status, got.end_of_run));
                return;
            end
            want = due_items.pop_front();
            if (got.out_byte !== want.out_byte) begin
                report_mismatch($sformatf("out_byte %h, wanted %h", got.out_byte, want.out_byte));
            end
            if (got.byte_valid !== want.byte_valid) begin
                report_mismatch($sformatf("byte_valid %b, wanted %b",
                    got.byte_valid, want.byte_valid));
            end
            if (got.status !== want.status) begin
                report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
            end
            if (got.end_of_run !== want.end_of_run) begin
                report_mismatch($sformatf("end_of_run %b, wanted %b",
                    got.end_of_run, want.end_of_run));
            end
        endtask

        task check_drained();
            if (due_items.size() != 0) begin
                report_mismatch($sformatf("%0d items never arrived", due_items.size()));
            end
        endtask
    endclass

    localparam string ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 270;
    localparam int TAIL_CYCLES  = 20;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    in_item_t  s_data  = '0;
    logic      s_ready;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    bit calm = 1'b0;
    int cycles = 0;
    b64_decode_checker chk;

    base64_stream_decoder_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** base64_stream_decoder_unit: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) chk.take_char(s_data);
            if (m_valid && m_ready) chk.check_item(m_data);
        end
    end

    always @(negedge aclk) begin
        if (aresetn) m_ready <= calm || ($urandom_range(99) >= 26);
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        while (!calm && $urandom_range(99) < 26) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{char_code: c, is_last: last};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_str(input string str, input bit ends_text);
        int i;
        for (i = 0; i < str.len(); i++) begin
            send_char(str[i], ends_text && (i == str.len() - 1));
        end
    endtask

    task automatic send_text(input logic [7:0] txt[$]);
        int i;
        for (i = 0; i < txt.size(); i++) begin
            send_char(txt[i], i == txt.size() - 1);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (chk.awaiting() != 0);
    endtask

    // Builds one text: mostly well-formed base64 of random bytes, otherwise a broken variant.
    function automatic void make_text(ref logic [7:0] txt[$], ref int body_len);
        logic [7:0]  ws[4] = '{CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF};
        logic [7:0]  body[$];
        logic [23:0] w;
        int          n;
        int          i;
        int          kind;
        txt.delete();
        n = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        for (i = 0; i < n; i += 3) begin
            w = 24'($urandom());
            body.push_back(ALPHABET[w[23:18]]);
            body.push_back(ALPHABET[w[17:12]]);
            body.push_back((n - i >= 2) ? ALPHABET[w[11:6]] : CHAR_PAD);
            body.push_back((n - i >= 3) ? ALPHABET[w[5:0]] : CHAR_PAD);
        end
        kind = $urandom_range(99);
        if (kind < 8) begin
            while (body.size() > 0 && body[body.size() - 1] == CHAR_PAD) void'(body.pop_back());
        end else if (kind < 16) begin
            body[$urandom_range(body.size() - 1)] = 8'($urandom_range(255));
        end else if (kind < 22) begin
            body.insert($urandom_range(body.size() - 1, 1), ws[$urandom_range(1)]);
        end else if (kind < 28) begin
            repeat ($urandom_range(3, 1)) void'(body.pop_back());
        end else if (kind < 36) begin
            body.delete();
            repeat ($urandom_range(8, 1)) body.push_back(8'($urandom_range(255)));
        end else if (kind < 41) begin
            body.delete();
        end else if (kind < 46) begin
            body[4 * $urandom_range((body.size() - 1) / 4) + $urandom_range(1)] = CHAR_PAD;
        end
        if ($urandom_range(99) < 30 || body.size() == 0) begin
            repeat ($urandom_range(3, 1)) txt.push_back(ws[$urandom_range(3)]);
        end
        body_len = body.size();
        foreach (body[k]) txt.push_back(body[k]);
        if ($urandom_range(99) < 25) begin
            repeat ($urandom_range(2, 1)) begin
                txt.push_back(ws[$urandom_range(1)]);
                body_len++;
            end
        end
    endfunction

    initial begin
        logic [7:0] txt[$];
        int         body_len;
        int         sent;
        bit         paused;
        chk = new(ALPHABET);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_str("\n \r\t+/9=", 1'b1);
        send_str("QQ=", 1'b0);
        send_char(8'hFF, 1'b0);
        send_str("Az", 1'b1);
        send_str(" ", 1'b1);
        send_char(CHAR_PAD, 1'b0);
        send_char("A", 1'b0);
        send_char(8'h00, 1'b0);
        send_str("B\t\n", 1'b1);
        send_str("//// ", 1'b1);
        wait_drained();

        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            calm = (sent >= 110) && (sent < 190);
            if (!paused && sent >= 220) begin
                wait_drained();
                paused = 1'b1;
            end
            make_text(txt, body_len);
            send_text(txt);
            sent += body_len;
        end
        calm = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        chk.check_drained();
        if (chk.fails == 0) begin
            $display("** base64_stream_decoder_unit: PASSED **");
        end else begin
            $display("** base64_stream_decoder_unit: FAILED **");
        end
        $finish;
    end
endmodule

>>> filelist.f
src/b64d_pkg.sv
src/b64d_step.sv
src/base64_stream_decoder_unit.sv
tb/tb_top.sv
